// ===== sv/i2cmw_pkg.sv =====
package i2cmw_pkg;

	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	localparam logic REG_DEVICE_ADDRESS = 1'b0;
	localparam logic REG_ACK_TIMEOUT    = 1'b1;

	localparam logic [6:0] DEVICE_ADDRESS_RESET = 7'd42;
	localparam logic [9:0] ACK_TIMEOUT_RESET    = 10'd250;

	localparam logic [2:0] BYTE_HIGH = 3'd3;
	localparam logic [2:0] BYTE_LOW  = 3'd4;
	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	typedef enum logic [3:0] {
		PH_IDLE      = 4'd0,
		PH_START_LOW = 4'd1,
		PH_TX_LOW    = 4'd2,
		PH_TX_HIGH   = 4'd3,
		PH_ACK_LOW   = 4'd4,
		PH_ACK_HIGH  = 4'd5,
		PH_RS_LOW    = 4'd6,
		PH_RS_HIGH   = 4'd7,
		PH_RS_START  = 4'd8,
		PH_RX_LOW    = 4'd9,
		PH_RX_HIGH   = 4'd10,
		PH_MACK_LOW  = 4'd11,
		PH_MACK_HIGH = 4'd12,
		PH_STOP_LOW  = 4'd13,
		PH_STOP_HIGH = 4'd14,
		PH_STOP_END  = 4'd15
	} phase_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  register_address;
		logic [15:0] write_data;
		logic        sda_in;
	} item_t;

	typedef struct packed {
		logic        scl;
		logic        sda_out;
		logic        busy_res;
		logic        done_res;
		logic        ok;
		logic [15:0] read_data;
	} result_t;

	typedef struct packed {
		logic [6:0] device_address;
		logic [9:0] ack_timeout;
	} cfg_t;

endpackage

// ===== sv/i2cmw_if.sv =====
interface i2cmw_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  register_address;
	logic [15:0] write_data;
	logic        sda_in;

	modport source (output valid, kind, register_address, write_data, sda_in, input ready);
	modport sink (input valid, kind, register_address, write_data, sda_in, output ready);
endinterface

interface i2cmw_result_if;
	logic        valid;
	logic        ready;
	logic        scl;
	logic        sda_out;
	logic        busy_res;
	logic        done_res;
	logic        ok;
	logic [15:0] read_data;

	modport source (output valid, scl, sda_out, busy_res, done_res, ok, read_data, input ready);
	modport sink (input valid, scl, sda_out, busy_res, done_res, ok, read_data, output ready);
endinterface

interface i2cmw_cfg_if;
	logic       valid;
	logic       ready;
	logic       index;
	logic [9:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/i2cmw_cfg.sv =====
module i2cmw_cfg (
	input  logic                clk,
	input  logic                arst_n,
	i2cmw_cfg_if.sink           cfg_ch,
	output i2cmw_pkg::cfg_t     cfg
);

	logic [6:0] device_address_q;
	logic [9:0] ack_timeout_q;

	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_address_q <= i2cmw_pkg::DEVICE_ADDRESS_RESET;
			ack_timeout_q    <= i2cmw_pkg::ACK_TIMEOUT_RESET;
		end else if (cfg_ch.valid) begin
			case (cfg_ch.index)
				i2cmw_pkg::REG_DEVICE_ADDRESS: device_address_q <= cfg_ch.data[6:0];
				i2cmw_pkg::REG_ACK_TIMEOUT:    ack_timeout_q    <= cfg_ch.data;
				default: ;
			endcase
		end
	end

	assign cfg.device_address = device_address_q;
	assign cfg.ack_timeout    = ack_timeout_q;

endmodule

// ===== sv/i2cmw_core.sv =====
module i2cmw_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  i2cmw_pkg::item_t     item,
	input  i2cmw_pkg::cfg_t      cfg,
	output i2cmw_pkg::result_t   res
);

	i2cmw_pkg::phase_t phase_q, phase_d;
	logic [3:0]  bit_count_q, bit_count_d;
	logic [7:0]  shift_q, shift_d;
	logic [2:0]  byte_index_q, byte_index_d;
	logic        is_read_q, is_read_d;
	logic [15:0] word_q, word_d;
	logic [9:0]  wait_q, wait_d;
	logic        status_ok_q, status_ok_d;
	logic [7:0]  reg_latch_q, reg_latch_d;

	logic        scl, sda, busy, done;
	logic [3:0]  bc_inc;
	logic [2:0]  bi_inc;
	logic [7:0]  rx_shift;
	logic [10:0] wait_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= i2cmw_pkg::PH_IDLE;
			bit_count_q  <= '0;
			shift_q      <= '0;
			byte_index_q <= '0;
			is_read_q    <= 1'b0;
			word_q       <= '0;
			wait_q       <= '0;
			status_ok_q  <= 1'b0;
			reg_latch_q  <= '0;
		end else if (step) begin
			phase_q      <= phase_d;
			bit_count_q  <= bit_count_d;
			shift_q      <= shift_d;
			byte_index_q <= byte_index_d;
			is_read_q    <= is_read_d;
			word_q       <= word_d;
			wait_q       <= wait_d;
			status_ok_q  <= status_ok_d;
			reg_latch_q  <= reg_latch_d;
		end
	end

	assign bc_inc   = bit_count_q + 4'd1;
	assign bi_inc   = byte_index_q + 3'd1;
	assign rx_shift = {shift_q[6:0], item.sda_in};
	assign wait_inc = {1'b0, wait_q} + 11'd1;

	always_comb begin
		phase_d      = phase_q;
		bit_count_d  = bit_count_q;
		shift_d      = shift_q;
		byte_index_d = byte_index_q;
		is_read_d    = is_read_q;
		word_d       = word_q;
		wait_d       = wait_q;
		status_ok_d  = status_ok_q;
		reg_latch_d  = reg_latch_q;
		scl  = 1'b1;
		sda  = 1'b1;
		busy = 1'b1;
		done = 1'b0;
		case (phase_q)
			i2cmw_pkg::PH_IDLE: begin
				if (item.kind == i2cmw_pkg::KIND_WRITE || item.kind == i2cmw_pkg::KIND_READ) begin
					is_read_d    = (item.kind == i2cmw_pkg::KIND_READ);
					word_d       = (item.kind == i2cmw_pkg::KIND_WRITE) ? item.write_data : 16'd0;
					reg_latch_d  = item.register_address;
					status_ok_d  = 1'b1;
					byte_index_d = '0;
					wait_d       = '0;
					shift_d      = {cfg.device_address, 1'b0};
					sda          = 1'b0;
					phase_d      = i2cmw_pkg::PH_START_LOW;
				end else begin
					busy = 1'b0;
				end
			end
			i2cmw_pkg::PH_START_LOW: begin
				scl         = 1'b0;
				sda         = 1'b0;
				bit_count_d = '0;
				phase_d     = i2cmw_pkg::PH_TX_LOW;
			end
			i2cmw_pkg::PH_TX_LOW: begin
				scl     = 1'b0;
				sda     = shift_q[7];
				phase_d = i2cmw_pkg::PH_TX_HIGH;
			end
			i2cmw_pkg::PH_TX_HIGH: begin
				sda         = shift_q[7];
				shift_d     = {shift_q[6:0], 1'b0};
				bit_count_d = bc_inc;
				if (bc_inc >= i2cmw_pkg::BITS_PER_BYTE) begin
					wait_d  = '0;
					phase_d = i2cmw_pkg::PH_ACK_LOW;
				end else begin
					phase_d = i2cmw_pkg::PH_TX_LOW;
				end
			end
			i2cmw_pkg::PH_ACK_LOW: begin
				scl     = 1'b0;
				phase_d = i2cmw_pkg::PH_ACK_HIGH;
			end
			i2cmw_pkg::PH_ACK_HIGH: begin
				if (!item.sda_in) begin
					byte_index_d = bi_inc;
					if (bi_inc == 3'd1) begin
						shift_d     = reg_latch_q;
						bit_count_d = '0;
						phase_d     = i2cmw_pkg::PH_TX_LOW;
					end else if (is_read_q) begin
						if (bi_inc == 3'd2) begin
							phase_d = i2cmw_pkg::PH_RS_LOW;
						end else begin
							shift_d     = '0;
							bit_count_d = '0;
							phase_d     = i2cmw_pkg::PH_RX_LOW;
						end
					end else if (bi_inc == 3'd2) begin
						shift_d     = word_q[15:8];
						bit_count_d = '0;
						phase_d     = i2cmw_pkg::PH_TX_LOW;
					end else if (bi_inc == 3'd3) begin
						shift_d     = word_q[7:0];
						bit_count_d = '0;
						phase_d     = i2cmw_pkg::PH_TX_LOW;
					end else begin
						phase_d = i2cmw_pkg::PH_STOP_LOW;
					end
				end else if (wait_inc >= {1'b0, cfg.ack_timeout}) begin
					status_ok_d = 1'b0;
					phase_d     = i2cmw_pkg::PH_STOP_LOW;
				end else begin
					wait_d = wait_inc[9:0];
				end
			end
			i2cmw_pkg::PH_RS_LOW: begin
				scl     = 1'b0;
				phase_d = i2cmw_pkg::PH_RS_HIGH;
			end
			i2cmw_pkg::PH_RS_HIGH: begin
				phase_d = i2cmw_pkg::PH_RS_START;
			end
			i2cmw_pkg::PH_RS_START: begin
				sda     = 1'b0;
				shift_d = {cfg.device_address, 1'b1};
				phase_d = i2cmw_pkg::PH_START_LOW;
			end
			i2cmw_pkg::PH_RX_LOW: begin
				scl     = 1'b0;
				phase_d = i2cmw_pkg::PH_RX_HIGH;
			end
			i2cmw_pkg::PH_RX_HIGH: begin
				shift_d     = rx_shift;
				bit_count_d = bc_inc;
				if (bc_inc >= i2cmw_pkg::BITS_PER_BYTE) begin
					if (byte_index_q == i2cmw_pkg::BYTE_HIGH) begin
						word_d = {rx_shift, 8'h00};
					end else begin
						word_d = {word_q[15:8], rx_shift};
					end
					phase_d = i2cmw_pkg::PH_MACK_LOW;
				end else begin
					phase_d = i2cmw_pkg::PH_RX_LOW;
				end
			end
			i2cmw_pkg::PH_MACK_LOW: begin
				scl     = 1'b0;
				sda     = (byte_index_q != i2cmw_pkg::BYTE_HIGH);
				phase_d = i2cmw_pkg::PH_MACK_HIGH;
			end
			i2cmw_pkg::PH_MACK_HIGH: begin
				sda = (byte_index_q != i2cmw_pkg::BYTE_HIGH);
				if (byte_index_q == i2cmw_pkg::BYTE_HIGH) begin
					byte_index_d = i2cmw_pkg::BYTE_LOW;
					shift_d      = '0;
					bit_count_d  = '0;
					phase_d      = i2cmw_pkg::PH_RX_LOW;
				end else begin
					phase_d = i2cmw_pkg::PH_STOP_LOW;
				end
			end
			i2cmw_pkg::PH_STOP_LOW: begin
				scl     = 1'b0;
				sda     = 1'b0;
				phase_d = i2cmw_pkg::PH_STOP_HIGH;
			end
			i2cmw_pkg::PH_STOP_HIGH: begin
				sda     = 1'b0;
				phase_d = i2cmw_pkg::PH_STOP_END;
			end
			i2cmw_pkg::PH_STOP_END: begin
				busy    = 1'b0;
				done    = 1'b1;
				phase_d = i2cmw_pkg::PH_IDLE;
			end
			default: begin
				busy    = 1'b0;
				phase_d = i2cmw_pkg::PH_IDLE;
			end
		endcase
	end

	assign res.scl       = scl;
	assign res.sda_out   = sda;
	assign res.busy_res  = busy;
	assign res.done_res  = done;
	assign res.ok        = !busy && status_ok_d;
	assign res.read_data = (!busy && is_read_d && status_ok_d) ? word_d : 16'd0;

endmodule

// ===== sv/i2c_master_word_transfer_unit.sv =====
// I2C word read/write master, data high byte first, driven one bus tick at a time: every
// accepted item is one half-bit period and yields exactly one result with the SCL/SDA levels
// and status for that tick. One item is taken per clock while the result side is not
// stalled; a result is presented once its item has landed in the input register and the
// sequencer step has then loaded the result register, and the sequencer state register
// advances once per step. Configuration writes are registered and are always ready.
module i2c_master_word_transfer_unit (
	input  logic            clk,
	input  logic            arst_n,
	i2cmw_item_if.sink      in_ch,
	i2cmw_result_if.source  out_ch,
	i2cmw_cfg_if.sink       cfg_ch
);

	i2cmw_pkg::item_t   item_s1;
	logic               valid_s1;
	i2cmw_pkg::result_t res_s2;
	logic               valid_s2;
	i2cmw_pkg::result_t core_res;
	i2cmw_pkg::cfg_t    cfg;
	logic               adv;
	logic               take;

	assign adv         = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_ch.ready = !valid_s1 || adv;
	assign take        = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (out_ch.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.kind             <= in_ch.kind;
			item_s1.register_address <= in_ch.register_address;
			item_s1.write_data       <= in_ch.write_data;
			item_s1.sda_in           <= in_ch.sda_in;
		end
		if (adv) begin
			res_s2 <= core_res;
		end
	end

	i2cmw_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_ch (cfg_ch),
		.cfg    (cfg)
	);

	i2cmw_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (core_res)
	);

	assign out_ch.valid     = valid_s2;
	assign out_ch.scl       = res_s2.scl;
	assign out_ch.sda_out   = res_s2.sda_out;
	assign out_ch.busy_res  = res_s2.busy_res;
	assign out_ch.done_res  = res_s2.done_res;
	assign out_ch.ok        = res_s2.ok;
	assign out_ch.read_data = res_s2.read_data;

endmodule

// ===== sv/i2cmw_checker.sv =====
module i2cmw_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        scl,
	input logic        sda_out,
	input logic        busy_res,
	input logic        done_res,
	input logic        ok,
	input logic [15:0] read_data
);

	a_done_is_stop_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> scl && sda_out && !busy_res)
		else $error("done transfer without released bus");

	a_busy_hides_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && busy_res |-> !ok && read_data == 16'd0)
		else $error("status shown while busy");

	a_fail_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ok |-> read_data == 16'd0)
		else $error("read data shown after failed transfer");

	a_empty_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(scl) && $stable(sda_out)
			&& $stable(busy_res) && $stable(done_res) && $stable(ok) && $stable(read_data))
		else $error("stalled result changed");

endmodule

bind i2c_master_word_transfer_unit i2cmw_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.scl       (out_ch.scl),
	.sda_out   (out_ch.sda_out),
	.busy_res  (out_ch.busy_res),
	.done_res  (out_ch.done_res),
	.ok        (out_ch.ok),
	.read_data (out_ch.read_data)
);

// ===== verif/i2c_master_word_transfer_unit_tb.sv =====
module i2c_master_word_transfer_unit_tb;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam logic [2:0] SEND_REGISTER = 3'd1;
	localparam logic [2:0] SEND_DATA_HIGH = 3'd2;
	localparam logic [2:0] REPEAT_START = 3'd2;
	localparam logic [2:0] SEND_DATA_LOW = 3'd3;
	localparam int NO_REFUSAL = -1;
	localparam int RANDOM_TICKS = 200;
	localparam int WATCHDOG_LIMIT = 400;
	localparam int DRAIN_CYCLES = 8;
	localparam int SHOWN_ERRORS = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	i2cmw_item_if item_if();
	i2cmw_result_if result_if();
	i2cmw_cfg_if cfg_if();

	i2c_master_word_transfer_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (item_if),
		.out_ch (result_if),
		.cfg_ch (cfg_if)
	);

	always #5 clk = ~clk;

	// master model state
	i2cmw_pkg::phase_t bus_phase = i2cmw_pkg::PH_IDLE;
	logic [3:0]  bit_no = '0;
	logic [7:0]  shifter = '0;
	logic [2:0]  byte_no = '0;
	logic        rd_mode = 1'b0;
	logic [15:0] word = '0;
	logic [9:0]  waited = '0;
	logic        good = 1'b0;
	logic [7:0]  reg_byte = '0;
	logic [6:0]  dev_addr = i2cmw_pkg::DEVICE_ADDRESS_RESET;
	logic [9:0]  ack_limit = i2cmw_pkg::ACK_TIMEOUT_RESET;

	i2cmw_pkg::result_t pending_levels[$];
	i2cmw_pkg::result_t want_levels;
	i2cmw_pkg::result_t got_levels;

	bit src_quiet = 1'b0;
	bit sink_quiet = 1'b0;
	bit busy_noise = 1'b0;
	int refuse_byte = NO_REFUSAL;
	int unsigned stall_left = 0;
	int unsigned quiet_cycles = 0;

	int unsigned ticks_sent = 0;
	int unsigned results_checked = 0;
	int unsigned errors = 0;
	int unsigned writes_started = 0;
	int unsigned reads_started = 0;
	int unsigned refusals = 0;
	int unsigned cfg_writes = 0;

	function automatic i2cmw_pkg::result_t step_master(input i2cmw_pkg::item_t it);
		i2cmw_pkg::result_t r;
		r = '0;
		r.scl = 1'b1;
		r.sda_out = 1'b1;
		r.busy_res = 1'b1;
		case (bus_phase)
			i2cmw_pkg::PH_IDLE: begin
				if (it.kind == i2cmw_pkg::KIND_WRITE || it.kind == i2cmw_pkg::KIND_READ) begin
					rd_mode = (it.kind == i2cmw_pkg::KIND_READ);
					word = rd_mode ? 16'h0000 : it.write_data;
					reg_byte = it.register_address;
					good = 1'b1;
					byte_no = '0;
					waited = '0;
					shifter = {dev_addr, 1'b0};
					r.sda_out = 1'b0;
					bus_phase = i2cmw_pkg::PH_START_LOW;
					if (rd_mode)
						reads_started++;
					else
						writes_started++;
				end else begin
					r.busy_res = 1'b0;
				end
			end
			i2cmw_pkg::PH_START_LOW: begin
				r.scl = 1'b0;
				r.sda_out = 1'b0;
				bit_no = '0;
				bus_phase = i2cmw_pkg::PH_TX_LOW;
			end
			i2cmw_pkg::PH_TX_LOW: begin
				r.scl = 1'b0;
				r.sda_out = shifter[7];
				bus_phase = i2cmw_pkg::PH_TX_HIGH;
			end
			i2cmw_pkg::PH_TX_HIGH: begin
				r.sda_out = shifter[7];
				shifter = {shifter[6:0], 1'b0};
				bit_no = bit_no + 4'd1;
				if (bit_no >= i2cmw_pkg::BITS_PER_BYTE) begin
					waited = '0;
					bus_phase = i2cmw_pkg::PH_ACK_LOW;
				end else begin
					bus_phase = i2cmw_pkg::PH_TX_LOW;
				end
			end
			i2cmw_pkg::PH_ACK_LOW: begin
				r.scl = 1'b0;
				bus_phase = i2cmw_pkg::PH_ACK_HIGH;
			end
			i2cmw_pkg::PH_ACK_HIGH: begin
				if (!it.sda_in) begin
					byte_no = byte_no + 3'd1;
					bit_no = '0;
					bus_phase = i2cmw_pkg::PH_TX_LOW;
					if (byte_no == SEND_REGISTER)
						shifter = reg_byte;
					else if (!rd_mode && byte_no == SEND_DATA_HIGH)
						shifter = word[15:8];
					else if (!rd_mode && byte_no == SEND_DATA_LOW)
						shifter = word[7:0];
					else if (!rd_mode)
						bus_phase = i2cmw_pkg::PH_STOP_LOW;
					else if (byte_no == REPEAT_START)
						bus_phase = i2cmw_pkg::PH_RS_LOW;
					else begin
						shifter = '0;
						bus_phase = i2cmw_pkg::PH_RX_LOW;
					end
				end else if ({1'b0, waited} + 11'd1 >= {1'b0, ack_limit}) begin
					good = 1'b0;
					refusals++;
					bus_phase = i2cmw_pkg::PH_STOP_LOW;
				end else begin
					waited = waited + 10'd1;
				end
			end
			i2cmw_pkg::PH_RS_LOW: begin
				r.scl = 1'b0;
				bus_phase = i2cmw_pkg::PH_RS_HIGH;
			end
			i2cmw_pkg::PH_RS_HIGH: begin
				bus_phase = i2cmw_pkg::PH_RS_START;
			end
			i2cmw_pkg::PH_RS_START: begin
				r.sda_out = 1'b0;
				shifter = {dev_addr, 1'b1};
				bus_phase = i2cmw_pkg::PH_START_LOW;
			end
			i2cmw_pkg::PH_RX_LOW: begin
				r.scl = 1'b0;
				bus_phase = i2cmw_pkg::PH_RX_HIGH;
			end
			i2cmw_pkg::PH_RX_HIGH: begin
				shifter = {shifter[6:0], it.sda_in};
				bit_no = bit_no + 4'd1;
				if (bit_no >= i2cmw_pkg::BITS_PER_BYTE) begin
					if (byte_no == i2cmw_pkg::BYTE_HIGH)
						word = {shifter, 8'h00};
					else
						word[7:0] = shifter;
					bus_phase = i2cmw_pkg::PH_MACK_LOW;
				end else begin
					bus_phase = i2cmw_pkg::PH_RX_LOW;
				end
			end
			i2cmw_pkg::PH_MACK_LOW: begin
				r.scl = 1'b0;
				r.sda_out = (byte_no != i2cmw_pkg::BYTE_HIGH);
				bus_phase = i2cmw_pkg::PH_MACK_HIGH;
			end
			i2cmw_pkg::PH_MACK_HIGH: begin
				r.sda_out = (byte_no != i2cmw_pkg::BYTE_HIGH);
				if (byte_no == i2cmw_pkg::BYTE_HIGH) begin
					byte_no = i2cmw_pkg::BYTE_LOW;
					shifter = '0;
					bit_no = '0;
					bus_phase = i2cmw_pkg::PH_RX_LOW;
				end else begin
					bus_phase = i2cmw_pkg::PH_STOP_LOW;
				end
			end
			i2cmw_pkg::PH_STOP_LOW: begin
				r.scl = 1'b0;
				r.sda_out = 1'b0;
				bus_phase = i2cmw_pkg::PH_STOP_HIGH;
			end
			i2cmw_pkg::PH_STOP_HIGH: begin
				r.sda_out = 1'b0;
				bus_phase = i2cmw_pkg::PH_STOP_END;
			end
			i2cmw_pkg::PH_STOP_END: begin
				r.busy_res = 1'b0;
				r.done_res = 1'b1;
				bus_phase = i2cmw_pkg::PH_IDLE;
			end
			default: begin
				r.busy_res = 1'b0;
				bus_phase = i2cmw_pkg::PH_IDLE;
			end
		endcase
		r.ok = r.busy_res ? 1'b0 : good;
		r.read_data = (!r.busy_res && rd_mode && good) ? word : 16'h0000;
		return r;
	endfunction

	function automatic int unsigned idle_draw(input bit quiet);
		return quiet ? 0 : $urandom_range(0, 15);
	endfunction

	// target side: acknowledge, stretch, refuse, or drive read data
	function automatic logic target_sda();
		if (bus_phase == i2cmw_pkg::PH_ACK_HIGH) begin
			if (int'(byte_no) == refuse_byte)
				return 1'b1;
			if ({1'b0, waited} + 11'd1 < {1'b0, ack_limit} && $urandom_range(0, 3) == 0)
				return 1'b1;
			return 1'b0;
		end
		return 1'($urandom_range(0, 1));
	endfunction

	function automatic i2cmw_pkg::item_t tick_item();
		i2cmw_pkg::item_t it;
		it.register_address = 8'($urandom);
		it.write_data = 16'($urandom);
		it.sda_in = target_sda();
		if (bus_phase == i2cmw_pkg::PH_IDLE)
			it.kind = $urandom_range(0, 1) ? i2cmw_pkg::KIND_TICK : KIND_UNUSED;
		else
			it.kind = busy_noise ? 2'($urandom_range(0, 3)) : i2cmw_pkg::KIND_TICK;
		return it;
	endfunction

	task automatic report_error(input string msg);
		errors++;
		if (errors <= SHOWN_ERRORS)
			$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	task automatic check_field(input string field, input int unsigned want,
			input int unsigned got);
		if (want != got)
			report_error($sformatf("%s expected %0h got %0h", field, want, got));
	endtask

	task automatic send_item(input i2cmw_pkg::item_t it);
		int unsigned gap;
		gap = idle_draw(src_quiet);
		if (gap != 0) begin
			item_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_if.valid <= 1'b1;
		item_if.kind <= it.kind;
		item_if.register_address <= it.register_address;
		item_if.write_data <= it.write_data;
		item_if.sda_in <= it.sda_in;
		do @(posedge clk); while (!(item_if.valid && item_if.ready));
		pending_levels.push_back(step_master(it));
		ticks_sent++;
	endtask

	task automatic wait_drained();
		item_if.valid <= 1'b0;
		while (pending_levels.size() != 0) @(posedge clk);
	endtask

	task automatic configure(input logic [9:0] addr_word, input logic [9:0] limit_word);
		logic [9:0] words[2];
		logic       regs[2];
		words[0] = addr_word;
		words[1] = limit_word;
		regs[0] = i2cmw_pkg::REG_DEVICE_ADDRESS;
		regs[1] = i2cmw_pkg::REG_ACK_TIMEOUT;
		wait_drained();
		cfg_if.valid <= 1'b1;
		for (int i = 0; i < 2; i++) begin
			cfg_if.index <= regs[i];
			cfg_if.data <= words[i];
			do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
			if (regs[i] == i2cmw_pkg::REG_DEVICE_ADDRESS)
				dev_addr = words[i][6:0];
			else
				ack_limit = words[i];
			cfg_writes++;
		end
		cfg_if.valid <= 1'b0;
	endtask

	task automatic tick_until(input i2cmw_pkg::phase_t stop_at);
		while (bus_phase != stop_at) send_item(tick_item());
	endtask

	task automatic start_transfer(input logic [1:0] kind, input logic [7:0] reg_addr,
			input logic [15:0] data, input int refuse);
		i2cmw_pkg::item_t it;
		it.kind = kind;
		it.register_address = reg_addr;
		it.write_data = data;
		it.sda_in = 1'($urandom_range(0, 1));
		refuse_byte = refuse;
		send_item(it);
	endtask

	task automatic run_transfer(input logic [1:0] kind, input logic [7:0] reg_addr,
			input logic [15:0] data, input int refuse);
		start_transfer(kind, reg_addr, data, refuse);
		tick_until(i2cmw_pkg::PH_IDLE);
		refuse_byte = NO_REFUSAL;
	endtask

	task automatic test_idle_bus();
		i2cmw_pkg::item_t it;
		for (int i = 0; i < 6; i++) begin
			it.kind = i[0] ? KIND_UNUSED : i2cmw_pkg::KIND_TICK;
			it.register_address = i[1] ? 8'hFF : 8'h00;
			it.write_data = i[1] ? 16'hFFFF : 16'h0000;
			it.sda_in = i[0];
			send_item(it);
		end
	endtask

	task automatic test_reset_defaults();
		run_transfer(i2cmw_pkg::KIND_WRITE, 8'h5A, 16'hA55A, 0);
		run_transfer(i2cmw_pkg::KIND_READ, 8'hC3, 16'h0000, NO_REFUSAL);
	endtask

	task automatic test_word_write();
		configure(10'h07F, 10'd1);
		run_transfer(i2cmw_pkg::KIND_WRITE, 8'hFF, 16'hFFFF, NO_REFUSAL);
		configure(10'h380, 10'd6);
		run_transfer(i2cmw_pkg::KIND_WRITE, 8'h00, 16'h0000, NO_REFUSAL);
	endtask

	task automatic test_word_read();
		configure(10'h055, 10'd5);
		run_transfer(i2cmw_pkg::KIND_READ, 8'hFF, 16'hFFFF, NO_REFUSAL);
		configure(10'h12A, 10'd2);
		run_transfer(i2cmw_pkg::KIND_READ, 8'h00, 16'h0000, NO_REFUSAL);
	endtask

	task automatic test_missing_ack();
		configure(10'($urandom), 10'd0);
		run_transfer(i2cmw_pkg::KIND_WRITE, 8'h11, 16'h2233, 0);
		configure(10'($urandom), 10'd3);
		run_transfer(i2cmw_pkg::KIND_WRITE, 8'h44, 16'h5566, int'(SEND_DATA_LOW));
		run_transfer(i2cmw_pkg::KIND_READ, 8'h77, 16'h0000, int'(REPEAT_START));
		run_transfer(i2cmw_pkg::KIND_READ, 8'h88, 16'h0000, int'(SEND_REGISTER));
	endtask

	task automatic test_busy_requests();
		busy_noise = 1'b1;
		run_transfer(i2cmw_pkg::KIND_WRITE, 8'($urandom), 16'($urandom), NO_REFUSAL);
		run_transfer(i2cmw_pkg::KIND_READ, 8'($urandom), 16'($urandom), NO_REFUSAL);
		busy_noise = 1'b0;
	endtask

	task automatic test_config_mid_transfer();
		configure(10'h01B, 10'd4);
		start_transfer(i2cmw_pkg::KIND_READ, 8'h3C, 16'h0000, NO_REFUSAL);
		tick_until(i2cmw_pkg::PH_RS_START);
		// new address must show up in the address+R byte
		configure(10'h064, 10'd9);
		tick_until(i2cmw_pkg::PH_ACK_HIGH);
		configure(10'h064, 10'd2);
		tick_until(i2cmw_pkg::PH_IDLE);
	endtask

	task automatic test_long_timeout();
		configure(10'h3FF, 10'd1023);
		run_transfer(i2cmw_pkg::KIND_WRITE, 8'h9E, 16'h1E2D, NO_REFUSAL);
	endtask

	task automatic test_random_traffic();
		int unsigned stop_at;
		logic [9:0]  addr_word;
		logic [9:0]  limit_word;
		logic [1:0]  kind;
		int          refuse;
		stop_at = ticks_sent + RANDOM_TICKS;
		while (ticks_sent < stop_at) begin
			addr_word = 10'($urandom);
			case ($urandom_range(0, 5))
				0: addr_word[6:0] = 7'h00;
				1: addr_word[6:0] = 7'h7F;
				default: ;
			endcase
			case ($urandom_range(0, 9))
				0: limit_word = 10'd0;
				1: limit_word = 10'd1;
				2: limit_word = 10'd1023;
				default: limit_word = 10'($urandom_range(2, 12));
			endcase
			configure(addr_word, limit_word);
			src_quiet = ($urandom_range(0, 3) == 0);
			sink_quiet = ($urandom_range(0, 3) == 0);
			busy_noise = 1'($urandom_range(0, 1));
			repeat ($urandom_range(2, 5)) begin
				repeat ($urandom_range(0, 3)) send_item(tick_item());
				kind = $urandom_range(0, 1) ? i2cmw_pkg::KIND_WRITE : i2cmw_pkg::KIND_READ;
				refuse = NO_REFUSAL;
				if (limit_word <= 10'd16 && $urandom_range(0, 4) == 0)
					refuse = $urandom_range(0, kind == i2cmw_pkg::KIND_WRITE ? 3 : 2);
				run_transfer(kind, 8'($urandom), 16'($urandom), refuse);
			end
		end
		src_quiet = 1'b0;
		sink_quiet = 1'b0;
		busy_noise = 1'b0;
	endtask

	// result side: stall, then compare each result with the oldest prediction
	always @(posedge clk) begin
		if (!arst_n) begin
			result_if.ready <= 1'b0;
			stall_left = 0;
		end else if (result_if.valid && result_if.ready) begin
			got_levels.scl = result_if.scl;
			got_levels.sda_out = result_if.sda_out;
			got_levels.busy_res = result_if.busy_res;
			got_levels.done_res = result_if.done_res;
			got_levels.ok = result_if.ok;
			got_levels.read_data = result_if.read_data;
			if (pending_levels.size() == 0) begin
				report_error($sformatf("result with nothing pending: %h", got_levels));
			end else begin
				want_levels = pending_levels.pop_front();
				check_field("scl", want_levels.scl, got_levels.scl);
				check_field("sda_out", want_levels.sda_out, got_levels.sda_out);
				check_field("busy_res", want_levels.busy_res, got_levels.busy_res);
				check_field("done_res", want_levels.done_res, got_levels.done_res);
				check_field("ok", want_levels.ok, got_levels.ok);
				check_field("read_data", want_levels.read_data, got_levels.read_data);
			end
			results_checked++;
			stall_left = idle_draw(sink_quiet);
			result_if.ready <= (stall_left == 0);
		end else if (!result_if.ready) begin
			if (stall_left <= 1) begin
				stall_left = 0;
				result_if.ready <= 1'b1;
			end else begin
				stall_left = stall_left - 1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready)
					|| (cfg_if.valid && cfg_if.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("no transfer for %0d cycles", quiet_cycles);
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		item_if.valid <= 1'b0;
		item_if.kind <= i2cmw_pkg::KIND_TICK;
		item_if.register_address <= '0;
		item_if.write_data <= '0;
		item_if.sda_in <= 1'b1;
		cfg_if.valid <= 1'b0;
		cfg_if.index <= i2cmw_pkg::REG_DEVICE_ADDRESS;
		cfg_if.data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_bus();
		test_reset_defaults();
		test_word_write();
		test_word_read();
		test_missing_ack();
		test_busy_requests();
		test_config_mid_transfer();
		test_long_timeout();
		test_random_traffic();

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d bus ticks, %0d word writes, %0d word reads, %0d dropped on no acknowledge",
			ticks_sent, writes_started, reads_started, refusals);
		$display("%0d register writes, %0d results compared, %0d mismatches",
			cfg_writes, results_checked, errors);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
